// File: rtl/dots_pkg.sv
// shared types and constants for the dhcp option tlv scanner
`default_nettype none

package dots_pkg;

  // size of the options area in bytes
  localparam int unsigned AREA_BYTES = 308;
  localparam int unsigned POS_W      = $clog2(AREA_BYTES + 1);

  // option code that ends the area
  localparam logic [7:0] END_CODE = 8'hFF;

  // result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam logic REG_TARGET_CODE = 1'b0;
  localparam logic REG_SCAN_MODE   = 1'b1;

  // scan phase within one record
  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  // kind of a result word
  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_CODE   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // one result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] value_length;
    logic       found;
    logic [7:0] option_count;
    logic       end_of_run;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/dots_result_fifo.sv
// small result queue: takes up to two words a cycle, gives one
`default_nettype none

module dots_result_fifo
  import dots_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  wire result_t push_a_i,
  input  wire result_t push_b_i,
  output logic         space_ok_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_word_o
);

  result_t                mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0]     count_q, count_d;
  logic [FIFO_AW-1:0]     wr_ptr_b;
  logic                   pop;

  // room for two more words
  assign space_ok_o  = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign out_valid_o = (count_q != '0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr_b    = wr_ptr_q + FIFO_AW'(1);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_AW'(push_cnt_i);
    rd_ptr_d = pop ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    count_d  = count_q + FIFO_CW'(push_cnt_i) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_b] <= push_b_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dhcp_option_tlv_scanner.sv
// top level of the dhcp option tlv scanner
// Usage:
//   Bytes of a DHCP options area enter on the in channel (valid/ready), one
//   word per byte with a first flag that restarts the scan. Result words
//   leave on the out channel (valid/ready): value bytes of the matching
//   option (extract mode), option codes (list mode) and one status word at
//   the end code or when the area size is reached.
//   Configuration (target code, scan mode) is written through cfg_we_i,
//   cfg_idx_i and cfg_data_i; the user writes only while the block is idle (not enforced).
// Timing and flow:
//   A byte is registered at acceptance and parsed once the result queue
//   has room; its words reach the out channel through that queue. One
//   byte is taken every cycle while the queue has room for two words; a
//   byte may yield two words (at the area end), which a four-word result
//   queue absorbs. Input ready drops only when that queue has fewer than two free places.
// Reset:
//   Clears all scan state and loads target code 53 and extract mode; a scan
//   is armed, so the first area needs no first flag.
// Stall:
//   When the receiver holds out_ready_i low the queue fills and input ready
//   falls; no word is lost or repeated.
`default_nettype none

module dhcp_option_tlv_scanner
  import dots_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  // input bytes
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] opt_byte_i,
  input  wire logic       first_i,
  // results
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_o,
  output logic [7:0]      value_length_o,
  output logic            found_o,
  output logic [7:0]      option_count_o,
  output logic            end_of_run_o
);

  // configuration registers
  logic [7:0] target_code_q;
  logic       scan_mode_q;

  // input stage
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       first_q;

  // scan state
  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       rem_q, rem_d;
  logic             cur_m_q, cur_m_d;
  logic             mf_q, mf_d;
  logic [7:0]       ml_q, ml_d;
  logic [7:0]       cnt_q, cnt_d;
  logic             done_q, done_d;

  // parse stage results
  logic       proc_fire;
  logic       space_ok;
  logic       emit_a, emit_b;
  result_t    item_a, status_w, push_a, push_b;
  logic [1:0] push_cnt;
  result_t    out_word;

  assign proc_fire  = in_valid_q && space_ok;
  assign in_ready_o = !in_valid_q || proc_fire;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_code_q <= 8'd53;
      scan_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_CODE: target_code_q <= cfg_data_i;
        REG_SCAN_MODE:   scan_mode_q   <= cfg_data_i[0];
        default:         target_code_q <= target_code_q;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= opt_byte_i;
      first_q <= first_i;
    end
  end

  // record parser
  always_comb begin
    logic [7:0] rem_dec;

    // a first flag starts from a cleared scan
    if (first_q) begin
      phase_d = PH_CODE;
      pos_d   = '0;
      rem_d   = '0;
      cur_m_d = 1'b0;
      mf_d    = 1'b0;
      ml_d    = '0;
      cnt_d   = '0;
      done_d  = 1'b0;
    end else begin
      phase_d = phase_q;
      pos_d   = pos_q;
      rem_d   = rem_q;
      cur_m_d = cur_m_q;
      mf_d    = mf_q;
      ml_d    = ml_q;
      cnt_d   = cnt_q;
      done_d  = done_q;
    end

    rem_dec = rem_d - 8'd1;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    item_a  = '0;

    if (!done_d) begin
      unique case (phase_d)
        PH_CODE: begin
          if (byte_q == END_CODE) begin
            done_d      = 1'b1;
            emit_a      = 1'b1;
            item_a.kind = KIND_STATUS;
          end else begin
            if (cnt_d != 8'hFF) begin
              cnt_d = cnt_d + 8'd1;
            end
            cur_m_d = (byte_q == target_code_q) && !mf_d;
            if (cur_m_d) begin
              mf_d = 1'b1;
            end
            if (scan_mode_q) begin
              emit_a      = 1'b1;
              item_a.kind = KIND_CODE;
              item_a.data = byte_q;
            end
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          rem_d = byte_q;
          if (cur_m_d) begin
            ml_d = byte_q;
          end
          if (byte_q == 8'd0) begin
            phase_d = PH_CODE;
            cur_m_d = 1'b0;
          end else begin
            phase_d = PH_VALUE;
          end
        end
        default: begin
          if (cur_m_d && !scan_mode_q) begin
            emit_a      = 1'b1;
            item_a.kind = KIND_VALUE;
            item_a.data = byte_q;
          end
          rem_d = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_d = PH_CODE;
            cur_m_d = 1'b0;
          end
        end
      endcase

      // area end closes the scan
      if (pos_d < POS_W'(AREA_BYTES)) begin
        pos_d = pos_d + POS_W'(1);
      end
      if (!done_d && pos_d >= POS_W'(AREA_BYTES)) begin
        done_d = 1'b1;
        emit_b = 1'b1;
      end
    end
  end

  // status word from the updated scan state
  always_comb begin
    status_w              = '0;
    status_w.kind         = KIND_STATUS;
    status_w.found        = mf_d;
    status_w.value_length = mf_d ? ml_d : 8'd0;
    status_w.option_count = cnt_d;
  end

  // order the words of this byte and mark the last one
  always_comb begin
    result_t a_full;

    a_full = item_a;
    if (item_a.kind == KIND_STATUS) begin
      a_full = status_w;
    end
    push_a   = '0;
    push_b   = '0;
    push_cnt = 2'd0;
    if (proc_fire) begin
      if (emit_a && emit_b) begin
        push_a            = a_full;
        push_b            = status_w;
        push_b.end_of_run = 1'b1;
        push_cnt          = 2'd2;
      end else if (emit_a) begin
        push_a            = a_full;
        push_a.end_of_run = 1'b1;
        push_cnt          = 2'd1;
      end else if (emit_b) begin
        push_a            = status_w;
        push_a.end_of_run = 1'b1;
        push_cnt          = 2'd1;
      end
    end
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      pos_q   <= '0;
      rem_q   <= '0;
      cur_m_q <= 1'b0;
      mf_q    <= 1'b0;
      ml_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else if (proc_fire) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      cur_m_q <= cur_m_d;
      mf_q    <= mf_d;
      ml_q    <= ml_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // result queue
  dots_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_a_i    (push_a),
    .push_b_i    (push_b),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word)
  );

  assign kind_o         = out_word.kind;
  assign data_o         = out_word.data;
  assign value_length_o = out_word.value_length;
  assign found_o        = out_word.found;
  assign option_count_o = out_word.option_count;
  assign end_of_run_o   = out_word.end_of_run;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// self-checking testbench for the dhcp option tlv scanner, with a built-in scan predictor
`timescale 1ns / 100ps

module tb_top;
  import dots_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned BYTES_PER_PHASE = 80;

  // shapes of generated option areas
  localparam int STYLE_WELL_FORMED = 0;
  localparam int STYLE_OVERRUN     = 1;
  localparam int STYLE_NOISE       = 2;

  typedef logic [7:0] octets_t [$];

  // dut signals
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = REG_TARGET_CODE;
  logic [7:0] cfg_data_i  = 8'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] opt_byte_i  = 8'd0;
  logic       first_i     = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] data_o;
  logic [7:0] value_length_o;
  logic       found_o;
  logic [7:0] option_count_o;
  logic       end_of_run_o;

  // configuration shadow
  logic [7:0] cfg_target = 8'd53;
  logic       cfg_list   = 1'b0;

  // predicted scan state
  phase_e           scan_phase;
  logic [POS_W-1:0] byte_pos;
  logic [7:0]       value_left;
  logic             cur_match;
  logic             match_seen;
  logic [7:0]       match_len;
  logic [7:0]       option_tally;
  logic             scan_over;

  // words still owed by the scanner
  result_t pending_words [$];

  // run bookkeeping
  logic        no_gaps = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned bytes_scanned = 0;
  int unsigned areas_sent = 0;
  int unsigned cycle_count = 0;

  dhcp_option_tlv_scanner uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opt_byte_i     (opt_byte_i),
    .first_i        (first_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_o         (data_o),
    .value_length_o (value_length_o),
    .found_o        (found_o),
    .option_count_o (option_count_o),
    .end_of_run_o   (end_of_run_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t watchdog expired, %0d words still owed", $time, pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // scan predictor
  // ---------------------------------------------------------------------------

  // clear everything a new area starts from
  function automatic void clear_scan();
    scan_phase   = PH_CODE;
    byte_pos     = '0;
    value_left   = 8'd0;
    cur_match    = 1'b0;
    match_seen   = 1'b0;
    match_len    = 8'd0;
    option_tally = 8'd0;
    scan_over    = 1'b0;
  endfunction

  // status fields are only filled in a status word
  function automatic result_t make_word(input kind_e k, input logic [7:0] d);
    result_t w;
    w      = '0;
    w.kind = k;
    w.data = d;
    if (k == KIND_STATUS) begin
      w.value_length = match_seen ? match_len : 8'd0;
      w.found        = match_seen;
      w.option_count = option_tally;
    end
    return w;
  endfunction

  // advance the scan by one accepted byte and queue the words it causes
  function automatic void predict_scan_step(input logic [7:0] b, input logic restart);
    result_t staged [2];
    int      n;
    n = 0;
    if (restart) clear_scan();
    if (scan_over) return;
    bytes_scanned++;

    case (scan_phase)
      PH_CODE: begin
        if (b == END_CODE) begin
          scan_over = 1'b1;
          staged[n] = make_word(KIND_STATUS, 8'd0);
          n++;
        end else begin
          if (option_tally != 8'hFF) option_tally++;
          cur_match = (b == cfg_target) && !match_seen;
          if (cur_match) match_seen = 1'b1;
          if (cfg_list) begin
            staged[n] = make_word(KIND_CODE, b);
            n++;
          end
          scan_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        value_left = b;
        if (cur_match) match_len = b;
        if (b == 8'd0) begin
          scan_phase = PH_CODE;
          cur_match  = 1'b0;
        end else begin
          scan_phase = PH_VALUE;
        end
      end
      default: begin
        if (cur_match && !cfg_list) begin
          staged[n] = make_word(KIND_VALUE, b);
          n++;
        end
        value_left--;
        if (value_left == 8'd0) begin
          scan_phase = PH_CODE;
          cur_match  = 1'b0;
        end
      end
    endcase

    // area size reached: the status follows the byte's own word
    if (byte_pos < AREA_BYTES) byte_pos++;
    if (!scan_over && byte_pos >= AREA_BYTES) begin
      scan_over = 1'b1;
      staged[n] = make_word(KIND_STATUS, 8'd0);
      n++;
    end

    if (n > 0) staged[n-1].end_of_run = 1'b1;
    for (int i = 0; i < n; i++) pending_words.push_back(staged[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  function automatic void compare_field(input string label, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  // compare one accepted word with the oldest prediction
  function automatic void check_word();
    result_t want;
    if (pending_words.size() == 0) begin
      $display("%0t unexpected word: expected none actual kind %0d data %0h",
               $time, kind_o, data_o);
      mismatch_count++;
    end else begin
      want = pending_words.pop_front();
      compare_field("kind", 8'(want.kind), 8'(kind_o));
      compare_field("data", want.data, data_o);
      compare_field("value_length", want.value_length, value_length_o);
      compare_field("found", 8'(want.found), 8'(found_o));
      compare_field("option_count", want.option_count, option_count_o);
      compare_field("end_of_run", 8'(want.end_of_run), 8'(end_of_run_o));
    end
    words_checked++;
  endfunction

  // receiver with a random stall before each word
  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_word();
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one byte after a random gap, predict at acceptance
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opt_byte_i <= b;
    first_i    <= restart;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_scan_step(b, restart);
  endtask

  task automatic send_area(input octets_t area, input logic restart);
    foreach (area[i]) send_byte(area[i], restart && (i == 0));
    areas_sent++;
  endtask

  // hold input until every owed word is out and the pipeline is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both registers on consecutive edges while idle
  task automatic write_config(input logic [7:0] target, input logic list_mode);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TARGET_CODE;
    cfg_data_i <= target;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SCAN_MODE;
    cfg_data_i <= {7'd0, list_mode};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_target = target;
    cfg_list   = list_mode;
  endtask

  // random options area; the target code is favoured so matches are common
  function automatic octets_t build_area(input int style);
    octets_t    area;
    int         opts;
    int         len;
    logic [7:0] code;
    if (style == STYLE_NOISE) begin
      repeat ($urandom_range(1, 24)) area.push_back(8'($urandom));
    end else begin
      opts = (style == STYLE_OVERRUN) ? 1000 : $urandom_range(0, 8);
      for (int i = 0; i < opts && area.size() < AREA_BYTES + 4; i++) begin
        code = ($urandom_range(0, 3) == 0) ? cfg_target : 8'($urandom_range(0, 254));
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        area.push_back(code);
        area.push_back(8'(len));
        repeat (len) area.push_back(8'($urandom));
      end
      if (style == STYLE_WELL_FORMED) begin
        area.push_back(END_CODE);
        // trailing bytes the scanner must ignore
        repeat ($urandom_range(0, 2)) area.push_back(8'($urandom));
      end
      while (area.size() > AREA_BYTES + 4) void'(area.pop_back());
    end
    return area;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: target 53 in extract mode, scan armed without a first flag
  task automatic test_reset_defaults();
    octets_t area;
    area = {8'd1, 8'd0, 8'd53, 8'd2, 8'hAA, 8'h00, 8'd53, 8'd1, 8'hCC, END_CODE};
    send_area(area, 1'b0);
    // ignored once the scan has ended
    send_byte(8'd53, 1'b0);
  endtask

  // list mode with code 0 as an ordinary record and 0xff as a value byte
  task automatic test_list_mode();
    octets_t area;
    write_config(8'h00, 1'b1);
    area = {8'h00, 8'd1, 8'hFF, 8'hFE, 8'd0, END_CODE};
    send_area(area, 1'b1);
  endtask

  // restart drops the unfinished scan; target 0xff never matches
  task automatic test_restart_mid_scan();
    octets_t area;
    write_config(8'hFF, 1'b0);
    area = {8'd7, 8'd3, 8'h01};
    send_area(area, 1'b1);
    area = {8'd7, 8'd0, END_CODE};
    send_area(area, 1'b1);
  endtask

  // area size reached: value cut off, and a match whose code is the last byte
  task automatic test_area_end();
    octets_t area;
    write_config(8'd12, 1'b0);
    area = {};
    repeat ((AREA_BYTES - 4) / 2) area = {area, 8'd3, 8'd0};
    area = {area, 8'd12, 8'd200, 8'h5A, 8'hA5, 8'h12, 8'h34};
    send_area(area, 1'b1);
    area = {};
    repeat ((AREA_BYTES - 4) / 2) area = {area, 8'd3, 8'd0};
    area = {area, 8'd9, 8'd1, 8'h77, 8'd12, 8'd4, 8'h01};
    send_area(area, 1'b1);
    // same in list mode: the last code and the status share one byte
    write_config(8'd12, 1'b1);
    send_area(area, 1'b1);
  endtask

  // random areas under several settings, mostly well formed
  task automatic test_random_areas();
    octets_t     area;
    int          pick;
    int          style;
    int unsigned goal;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_config(8'd53, 1'b0);
        1: write_config(8'd0, 1'b1);
        2: write_config(8'hFF, 1'b0);
        3: write_config(8'hFF, 1'b1);
        default: write_config(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
      goal = bytes_scanned + BYTES_PER_PHASE;
      while (bytes_scanned < goal) begin
        no_gaps = ($urandom_range(0, 4) == 0);
        pick    = $urandom_range(0, 99);
        style   = (pick < 80) ? STYLE_WELL_FORMED :
                  (pick < 85) ? STYLE_OVERRUN : STYLE_NOISE;
        area    = build_area(style);
        // some areas carry on from the previous scan
        send_area(area, $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 24) == 0) settle();
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_scan();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_list_mode();
    test_restart_mid_scan();
    test_area_end();
    test_random_areas();

    // drain
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $display("%0t %0d words never arrived: expected %0d actual 0",
               $time, pending_words.size(), pending_words.size());
      mismatch_count++;
    end

    $display("scanned %0d bytes over %0d areas in extract and list modes, %0d words checked",
             bytes_scanned, areas_sent, words_checked);
    $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
